[design/speck_block_cipher_128_128_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the Speck128/128 RTL.
// Each macro builds one labeled concurrent assertion on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPECK_BLOCK_CIPHER_128_128_ASSERT_SVH
`define SPECK_BLOCK_CIPHER_128_128_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPECK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPECK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/speck_pkg.sv]
// ----------------------------------------------------------------------------
// speck_pkg
// Shared constants, beat types, sequencer states and control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package speck_pkg;

  // Word size and number of rounds of Speck128/128.
  localparam int WORD_W = 64;
  localparam int ROUNDS = 32;

  // Round counter and round key store address width.
  localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // Configuration port geometry: two 64-bit registers at byte addresses 0 and 8.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // Register index codes.
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // Operation codes carried in the mode field.
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Input beat.
  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] block_low;
    logic [WORD_W-1:0] block_high;
  } speck_in_t;

  // Result beat.
  typedef struct packed {
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
  } speck_out_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_EXPAND,
    S_IDLE,
    S_RUN,
    S_HOLD
  } speck_state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic             exp_step;     // one key schedule round
    logic             exp_first;    // schedule starts from the key registers
    logic             blk_load;     // load an accepted block into the state
    logic             run_step;     // one cipher round
    logic             inv;          // inverse round
    logic             ram_we;       // store a round key
    logic [CNT_W-1:0] round_idx;    // current round, also the write address
    logic [CNT_W-1:0] ram_raddr;    // round key to fetch for the next cycle
    logic             out_load;     // fill the output register
    logic             out_from_reg; // output comes from the held state
  } speck_ctrl_t;

endpackage

`default_nettype wire

[design/speck_ram.sv]
// ----------------------------------------------------------------------------
// speck_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module speck_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/speck_round.sv]
// ----------------------------------------------------------------------------
// speck_round
// Shared Speck round unit: one forward or one inverse round around a
// single 64-bit adder that subtracts for the inverse round.
// ----------------------------------------------------------------------------
`default_nettype none

module speck_round (
  input  wire logic [speck_pkg::WORD_W-1:0] x_in,
  input  wire logic [speck_pkg::WORD_W-1:0] y_in,
  input  wire logic [speck_pkg::WORD_W-1:0] key,
  input  wire logic                         inv,
  output logic      [speck_pkg::WORD_W-1:0] x_out,
  output logic      [speck_pkg::WORD_W-1:0] y_out
);

  logic [speck_pkg::WORD_W-1:0] x_ror8;
  logic [speck_pkg::WORD_W-1:0] y_rol3;
  logic [speck_pkg::WORD_W-1:0] xy;
  logic [speck_pkg::WORD_W-1:0] y_inv;
  logic [speck_pkg::WORD_W-1:0] add_a;
  logic [speck_pkg::WORD_W-1:0] add_b;
  logic [speck_pkg::WORD_W-1:0] sum;

  // Fixed rotations are plain wiring.
  assign x_ror8 = {x_in[7:0], x_in[speck_pkg::WORD_W-1:8]};
  assign y_rol3 = {y_in[speck_pkg::WORD_W-4:0], y_in[speck_pkg::WORD_W-1:speck_pkg::WORD_W-3]};
  assign xy     = x_in ^ y_in;
  assign y_inv  = {xy[2:0], xy[speck_pkg::WORD_W-1:3]};

  // Forward adds ror8(x) + y; inverse subtracts (x ^ k) - y'.
  assign add_a = inv ? (x_in ^ key) : x_ror8;
  assign add_b = inv ? ~y_inv : y_in;
  assign sum   = add_a + add_b + speck_pkg::WORD_W'(inv);

  // Finish the round in the chosen direction.
  always_comb begin
    if (inv) begin
      x_out = {sum[speck_pkg::WORD_W-9:0], sum[speck_pkg::WORD_W-1:speck_pkg::WORD_W-8]};
      y_out = y_inv;
    end else begin
      x_out = sum ^ key;
      y_out = y_rol3 ^ (sum ^ key);
    end
  end

endmodule

`default_nettype wire

[design/speck_seq.sv]
// ----------------------------------------------------------------------------
// speck_seq
// Sequencer: runs the key schedule after reset and after every key write,
// then steps the shared round unit once per cycle for each accepted block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "speck_block_cipher_128_128_assert.svh"

module speck_seq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_mode,
  input  wire logic                   cfg_wr,
  input  wire logic                   out_free,
  output logic                        in_stall,
  output speck_pkg::speck_ctrl_t      ctrl
);

  localparam logic [speck_pkg::CNT_W-1:0] LAST = speck_pkg::CNT_W'(speck_pkg::ROUNDS - 1);

  speck_pkg::speck_state_t      state_r;
  speck_pkg::speck_state_t      state_nxt;
  logic [speck_pkg::CNT_W-1:0]  cnt_r;
  logic [speck_pkg::CNT_W-1:0]  cnt_nxt;
  logic [speck_pkg::CNT_W-1:0]  cnt_inc;
  logic                         mode_r;
  logic                         mode_nxt;
  logic                         accept;

  // New blocks are taken only when idle and no key write is under way.
  assign in_stall = (state_r != speck_pkg::S_IDLE) || cfg_wr;
  assign accept   = in_valid && !in_stall;
  assign cnt_inc  = cnt_r + speck_pkg::CNT_W'(1);

  // State, round counter and operation of the block in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= speck_pkg::S_EXPAND;
      cnt_r   <= '0;
      mode_r  <= speck_pkg::MODE_ENC;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Next state and datapath controls.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    mode_nxt       = mode_r;
    ctrl           = '0;
    ctrl.round_idx = cnt_r;

    unique case (state_r)
      speck_pkg::S_EXPAND: begin
        ctrl.exp_step  = 1'b1;
        ctrl.exp_first = (cnt_r == '0);
        ctrl.ram_we    = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = speck_pkg::S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      speck_pkg::S_IDLE: begin
        if (accept) begin
          ctrl.blk_load  = 1'b1;
          ctrl.ram_raddr = (in_mode == speck_pkg::MODE_DEC) ? LAST : '0;
          mode_nxt       = in_mode;
          state_nxt      = speck_pkg::S_RUN;
          cnt_nxt        = '0;
        end
      end
      speck_pkg::S_RUN: begin
        ctrl.run_step  = 1'b1;
        ctrl.inv       = (mode_r == speck_pkg::MODE_DEC);
        ctrl.ram_raddr = (mode_r == speck_pkg::MODE_DEC) ? (LAST - cnt_inc) : cnt_inc;
        if (cnt_r == LAST) begin
          cnt_nxt = '0;
          if (out_free) begin
            ctrl.out_load = 1'b1;
            state_nxt     = speck_pkg::S_IDLE;
          end else begin
            state_nxt = speck_pkg::S_HOLD;
          end
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      speck_pkg::S_HOLD: begin
        if (out_free) begin
          ctrl.out_load     = 1'b1;
          ctrl.out_from_reg = 1'b1;
          state_nxt         = speck_pkg::S_IDLE;
        end
      end
    endcase

    // A key write restarts the schedule from round zero.
    if (cfg_wr) begin
      state_nxt = speck_pkg::S_EXPAND;
      cnt_nxt   = '0;
    end
  end

  // Sequencing checks.
  `SPECK_ASSERT_NEXT(a_accept_starts_run, accept,
    (state_r == speck_pkg::S_RUN) && (cnt_r == '0), "accepted beat did not start round zero")
  `SPECK_ASSERT_NEXT(a_key_write_restarts, cfg_wr,
    (state_r == speck_pkg::S_EXPAND) && (cnt_r == '0), "key write did not restart the schedule")
  `SPECK_ASSERT_SAME(a_out_load_free, ctrl.out_load, out_free,
    "result loaded over a beat still waiting")
  `SPECK_ASSERT_NEXT(a_blocked_result_held,
    (state_r == speck_pkg::S_RUN) && (cnt_r == LAST) && !out_free && !cfg_wr,
    state_r == speck_pkg::S_HOLD, "finished block not held while output is busy")

endmodule

`default_nettype wire

[design/speck_block_cipher_128_128.sv]
// ----------------------------------------------------------------------------
// speck_block_cipher_128_128
// Speck128/128 ECB engine: 64-bit key words, round keys in a RAM, one shared
// round unit stepped once per cycle.
// Each accepted block runs all 32 rounds through the shared round unit; the last
// round loads the output register, or the result is held while the output is busy.
// A new block is taken only in the idle state, after the previous block has left
// the round unit and loaded the output register; a stalled output delays this.
// Reset, and every key write, runs the key schedule; input is stalled
// meanwhile. After reset the schedule uses the all-zero key.
// ----------------------------------------------------------------------------
`default_nettype none

module speck_block_cipher_128_128 (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire speck_pkg::speck_in_t             in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output speck_pkg::speck_out_t                 out_data,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [speck_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [speck_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [speck_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready
);

  speck_pkg::speck_ctrl_t        ctrl;
  logic                          cfg_wr;
  logic                          reg_idx;
  logic                          out_free;
  logic [speck_pkg::WORD_W-1:0]  key_low_r;
  logic [speck_pkg::WORD_W-1:0]  key_high_r;
  logic [speck_pkg::WORD_W-1:0]  x_r;
  logic [speck_pkg::WORD_W-1:0]  x_nxt;
  logic [speck_pkg::WORD_W-1:0]  y_r;
  logic [speck_pkg::WORD_W-1:0]  y_nxt;
  logic [speck_pkg::WORD_W-1:0]  src_x;
  logic [speck_pkg::WORD_W-1:0]  src_y;
  logic [speck_pkg::WORD_W-1:0]  rkey;
  logic [speck_pkg::WORD_W-1:0]  ram_rdata;
  logic [speck_pkg::WORD_W-1:0]  res_x;
  logic [speck_pkg::WORD_W-1:0]  res_y;
  logic                          out_valid_r;
  speck_pkg::speck_out_t         out_data_r;

  // Register decode: key_low at byte 0, key_high at byte 8.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3];
  assign prdata  = (reg_idx == speck_pkg::REG_KEY_HIGH) ? key_high_r : key_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_wr) begin
      if (reg_idx == speck_pkg::REG_KEY_HIGH) begin
        key_high_r <= pwdata;
      end else begin
        key_low_r <= pwdata;
      end
    end
  end

  // Sequencer.
  assign out_free = !out_valid_r || !out_stall;

  speck_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .cfg_wr   (cfg_wr),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  // Round key store, written during the schedule.
  speck_ram #(
    .WIDTH (speck_pkg::WORD_W),
    .DEPTH (speck_pkg::ROUNDS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ctrl.ram_we),
    .waddr (ctrl.round_idx),
    .wdata (src_y),
    .raddr (ctrl.ram_raddr),
    .rdata (ram_rdata)
  );

  // Round operands: the schedule starts from the key words and uses the
  // round index as its key.
  assign src_x = ctrl.exp_first ? key_high_r : x_r;
  assign src_y = ctrl.exp_first ? key_low_r : y_r;
  assign rkey  = ctrl.exp_step ? speck_pkg::WORD_W'(ctrl.round_idx) : ram_rdata;

  speck_round u_round (
    .x_in  (src_x),
    .y_in  (src_y),
    .key   (rkey),
    .inv   (ctrl.inv),
    .x_out (res_x),
    .y_out (res_y)
  );

  // Working state of the schedule or the block.
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctrl.blk_load) begin
      x_nxt = in_data.block_high;
      y_nxt = in_data.block_low;
    end else if (ctrl.exp_step || ctrl.run_step) begin
      x_nxt = res_x;
      y_nxt = res_y;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data_r.result_low  <= ctrl.out_from_reg ? y_r : res_y;
      out_data_r.result_high <= ctrl.out_from_reg ? x_r : res_x;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Speck128/128 block cipher testbench
// Drives blocks in both modes under several keys and checks every result
// against an in-bench cipher model. The model keeps its own copy of the keys
// and round keys. Both channels idle and stall at random, and at least once
// the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BEATS = 103;
  localparam int unsigned TAIL_CYCLES = 40;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  speck_pkg::speck_in_t             in_data;
  logic                             out_valid;
  logic                             out_stall;
  speck_pkg::speck_out_t            out_data;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [speck_pkg::CFG_ADDR_W-1:0] paddr;
  logic [speck_pkg::CFG_DATA_W-1:0] pwdata;
  logic [speck_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;

  // Cipher model state: key registers and the expanded round keys.
  bit [speck_pkg::WORD_W-1:0] key_word [2];
  bit [speck_pkg::WORD_W-1:0] round_key [speck_pkg::ROUNDS];

  speck_pkg::speck_out_t pending_results [$];
  int unsigned           fail_count;
  bit                    steady;
  bit                    hold_req;
  int unsigned           stall_left;

  speck_block_cipher_128_128 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Run the key schedule over the current key registers.
  function automatic void expand_key_schedule();
    bit [speck_pkg::WORD_W-1:0] a;
    bit [speck_pkg::WORD_W-1:0] b;
    a = key_word[0];
    b = key_word[1];
    for (int r = 0; r < speck_pkg::ROUNDS; r++) begin
      round_key[r] = a;
      b = ({b[7:0], b[speck_pkg::WORD_W-1:8]} + a) ^ speck_pkg::WORD_W'(r);
      a = {a[speck_pkg::WORD_W-4:0], a[speck_pkg::WORD_W-1:speck_pkg::WORD_W-3]} ^ b;
    end
  endfunction

  // Encrypt or decrypt one block with the current round keys.
  function automatic speck_pkg::speck_out_t cipher_block(logic mode,
                                                         logic [speck_pkg::WORD_W-1:0] lo,
                                                         logic [speck_pkg::WORD_W-1:0] hi);
    bit [speck_pkg::WORD_W-1:0] x;
    bit [speck_pkg::WORD_W-1:0] y;
    x = hi;
    y = lo;
    if (mode == speck_pkg::MODE_ENC) begin
      for (int r = 0; r < speck_pkg::ROUNDS; r++) begin
        x = ({x[7:0], x[speck_pkg::WORD_W-1:8]} + y) ^ round_key[r];
        y = {y[speck_pkg::WORD_W-4:0], y[speck_pkg::WORD_W-1:speck_pkg::WORD_W-3]} ^ x;
      end
    end else begin
      for (int r = speck_pkg::ROUNDS - 1; r >= 0; r--) begin
        y = y ^ x;
        y = {y[2:0], y[speck_pkg::WORD_W-1:3]};
        x = (x ^ round_key[r]) - y;
        x = {x[speck_pkg::WORD_W-9:0], x[speck_pkg::WORD_W-1:speck_pkg::WORD_W-8]};
      end
    end
    return speck_pkg::speck_out_t'{result_low: y, result_high: x};
  endfunction

  // Idle length: mostly none, sometimes a few cycles, rarely a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side stall: random stretches, plus one long hold on request.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      stall_left = HOLD_CYCLES - 1;
      hold_req = 1'b0;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = idle_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expected block.
  always @(posedge clk) begin
    speck_pkg::speck_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: %h", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_low !== want.result_low) begin
          $error("result_low: expected %h, got %h", want.result_low, out_data.result_low);
          fail_count++;
        end
        if (out_data.result_high !== want.result_high) begin
          $error("result_high: expected %h, got %h", want.result_high,
                 out_data.result_high);
          fail_count++;
        end
      end
    end
  end

  // Offer one block and wait until the block takes the beat.
  task automatic send_block(logic mode, logic [speck_pkg::WORD_W-1:0] lo,
                            logic [speck_pkg::WORD_W-1:0] hi);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_data  <= speck_pkg::speck_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= speck_pkg::speck_in_t'{mode: mode, block_low: lo, block_high: hi};
    do @(posedge clk); while (in_stall);
    pending_results.push_back(cipher_block(mode, lo, hi));
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one key register, then read it back.
  task automatic write_key(logic idx, logic [speck_pkg::WORD_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= speck_pkg::CFG_ADDR_W'(idx) << 3;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    key_word[idx] = value;
    expand_key_schedule();
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== key_word[idx]) begin
      $error("%s: expected %h, got %h",
             (idx == speck_pkg::REG_KEY_LOW) ? "key_low" : "key_high",
             key_word[idx], prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Blocks before any key write use the schedule of the all-zero key.
  task automatic test_reset_key();
    send_block(speck_pkg::MODE_ENC, '0, '0);
    send_block(speck_pkg::MODE_DEC, '0, '0);
    send_block(speck_pkg::MODE_ENC, '1, '1);
    send_block(speck_pkg::MODE_DEC, {$urandom, $urandom}, {$urandom, $urandom});
    drain();
  endtask

  // Published Speck128/128 vector, both directions.
  task automatic test_known_answer();
    speck_pkg::speck_out_t got;
    write_key(speck_pkg::REG_KEY_LOW, 64'h0706050403020100);
    write_key(speck_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    got = cipher_block(speck_pkg::MODE_ENC, 64'h7469206564616d20, 64'h6c61766975716520);
    if (got.result_low !== 64'h7860fedf5c570d18 ||
        got.result_high !== 64'ha65d985179783265) begin
      $error("cipher model disagrees with the known vector: %h", got);
      fail_count++;
    end
    send_block(speck_pkg::MODE_ENC, 64'h7469206564616d20, 64'h6c61766975716520);
    send_block(speck_pkg::MODE_DEC, 64'h7860fedf5c570d18, 64'ha65d985179783265);
    drain();
  endtask

  // Extreme keys and blocks; the key registers are changed one at a time.
  task automatic test_extremes();
    write_key(speck_pkg::REG_KEY_HIGH, '1);
    send_block(speck_pkg::MODE_ENC, '1, '1);
    send_block(speck_pkg::MODE_DEC, '0, '0);
    drain();
    write_key(speck_pkg::REG_KEY_LOW, '1);
    send_block(speck_pkg::MODE_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_block(speck_pkg::MODE_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    write_key(speck_pkg::REG_KEY_HIGH, '0);
    write_key(speck_pkg::REG_KEY_LOW, '0);
    send_block(speck_pkg::MODE_ENC, 64'h8000000000000000, 64'h0000000000000001);
    send_block(speck_pkg::MODE_DEC, 64'h0000000000000001, 64'h8000000000000000);
    send_block(speck_pkg::MODE_DEC, '1, '1);
    send_block(speck_pkg::MODE_ENC, '0, '1);
    drain();
  endtask

  // The result side holds off while blocks keep coming.
  task automatic test_backpressure();
    write_key(speck_pkg::REG_KEY_LOW, {$urandom, $urandom});
    steady   = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_block(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
    end
    drain();
    steady = 1'b0;
  endtask

  // Random blocks over a series of random keys; some beats decrypt an
  // earlier ciphertext so that round trips are exercised too.
  task automatic test_random();
    speck_pkg::speck_out_t      last_cipher;
    logic [speck_pkg::WORD_W-1:0] lo;
    logic [speck_pkg::WORD_W-1:0] hi;
    logic                       mode;
    last_cipher = '0;
    for (int p = 0; p < PHASES; p++) begin
      if ($urandom_range(0, 3) != 0) write_key(speck_pkg::REG_KEY_LOW, {$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) write_key(speck_pkg::REG_KEY_HIGH, {$urandom, $urandom});
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          mode = speck_pkg::MODE_DEC;
          lo   = last_cipher.result_low;
          hi   = last_cipher.result_high;
        end else begin
          mode = 1'($urandom_range(0, 1));
          lo   = {$urandom, $urandom};
          hi   = {$urandom, $urandom};
        end
        send_block(mode, lo, hi);
        if (mode == speck_pkg::MODE_ENC) last_cipher = pending_results[$];
      end
      drain();
    end
    steady = 1'b0;
  endtask

  // Reset once, run each test in turn, then report.
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    fail_count = 0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    stall_left = 0;
    key_word[0] = '0;
    key_word[1] = '0;
    expand_key_schedule();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_key();
    test_known_answer();
    test_extremes();
    test_backpressure();
    test_random();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
